/* sv/lwkd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwkd_pkg
// shared constants, types and sequencer states for the k-distinct window block
// ----------------------------------------------------------------------------
package lwkd_pkg;

  localparam int MAX_LEN  = 1024;
  localparam int ALPHABET = 26;

  localparam int LETTER_W = 5;
  localparam int TARGET_W = 5;
  localparam int DIST_W   = 5;
  localparam int POS_W    = $clog2(MAX_LEN + 1);
  localparam int HIST_AW  = $clog2(MAX_LEN);
  localparam int CNT_AW   = $clog2(ALPHABET);
  localparam int CNT_W    = 11;
  localparam int LEN_W    = 12;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COUNT,
    ST_CHECK,
    ST_HIST,
    ST_DEC,
    ST_SCORE,
    ST_EMIT
  } state_t;

  // request from the sequencer to the letter count store
  typedef struct packed {
    logic              rd_en;
    logic [CNT_AW-1:0] rd_addr;
    logic              wr_en;
    logic [CNT_AW-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
    logic              clear;
  } cnt_req_t;

endpackage

/* sv/longest_window_k_distinct_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_window_k_distinct_top
// longest window of a letter string holding exactly k distinct letters
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready: one letter per transaction, letter_index 0..25 with
//   last_of_string on the final letter of a string
//   out_valid/out_ready: one transaction per string, longest_length (-1 when
//   no window qualifies) and too_long when the 1024-entry ring overflowed
//   cfg_valid/cfg_ready: distinct_target, always ready, write only when idle
// sequence
//   a letter passes the count, check, score and emit states after the accept,
//   plus history read, count read and write-back for each letter pushed out
//   of the window front; letters out of the alphabet or past the ring skip
//   straight to emit; on a last letter out_valid rises together with in_ready
//   each letter leaves the window at most once over a string
// reset and stall
//   reset clears all string state and sets distinct_target to 1; counts are
//   masked by per-letter valid bits, so no memory sweep is needed
//   a stalled output holds its result; a new last letter then waits in the
//   sequencer until the output register frees up
// ----------------------------------------------------------------------------
module longest_window_k_distinct_top (
  input  logic                          clk,
  input  logic                          rst,
  // letter input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lwkd_pkg::LETTER_W-1:0] letter_index,
  input  logic                          last_of_string,
  // result output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [lwkd_pkg::LEN_W-1:0] longest_length,
  output logic                          too_long,
  // configuration
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lwkd_pkg::TARGET_W-1:0] distinct_target
);

  // sequencer state
  lwkd_pkg::state_t state, state_next;

  // string state registers
  logic [lwkd_pkg::TARGET_W-1:0]     target;
  logic [lwkd_pkg::DIST_W-1:0]       distinct, distinct_next;
  logic [lwkd_pkg::POS_W-1:0]        position, position_next;
  logic [lwkd_pkg::POS_W-1:0]        start, start_next;
  logic signed [lwkd_pkg::LEN_W-1:0] best, best_next;
  logic                              overflow, overflow_next;

  // current letter and the letter leaving the window front
  logic [lwkd_pkg::LETTER_W-1:0]     letter;
  logic                              last;
  logic [lwkd_pkg::LETTER_W-1:0]     old, old_next;

  // output register controls
  logic                              out_load;
  logic                              string_clear;

  // history ring access
  logic                              hist_wr_en;
  logic                              hist_rd_en;
  logic [lwkd_pkg::LETTER_W-1:0]     hist_rd_data;

  // letter count store
  lwkd_pkg::cnt_req_t                cnt_req;
  logic [lwkd_pkg::CNT_W-1:0]        cnt_rd_data;

  logic                              in_accept;
  logic [lwkd_pkg::POS_W-1:0]        win_len;

  assign in_ready  = (state == lwkd_pkg::ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign win_len   = position - start;

  lwkd_ram #(
    .WIDTH (lwkd_pkg::LETTER_W),
    .DEPTH (lwkd_pkg::MAX_LEN)
  ) u_hist_ram (
    .clk     (clk),
    .wr_en   (hist_wr_en),
    .wr_addr (position[lwkd_pkg::HIST_AW-1:0]),
    .wr_data (letter_index),
    .rd_en   (hist_rd_en),
    .rd_addr (start[lwkd_pkg::HIST_AW-1:0]),
    .rd_data (hist_rd_data)
  );

  lwkd_count_store u_count_store (
    .clk     (clk),
    .rst     (rst),
    .req     (cnt_req),
    .rd_data (cnt_rd_data)
  );

  // next state, memory requests and string state updates
  always_comb begin
    state_next    = state;
    distinct_next = distinct;
    position_next = position;
    start_next    = start;
    best_next     = best;
    overflow_next = overflow;
    old_next      = old;
    hist_wr_en    = 1'b0;
    hist_rd_en    = 1'b0;
    out_load      = 1'b0;
    string_clear  = 1'b0;
    cnt_req       = '0;

    unique case (state)
      lwkd_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (letter_index >= lwkd_pkg::LETTER_W'(lwkd_pkg::ALPHABET)) begin
            // letter outside the alphabet is ignored
            state_next = lwkd_pkg::ST_EMIT;
          end else if (position >= lwkd_pkg::POS_W'(lwkd_pkg::MAX_LEN)) begin
            // ring full, letter dropped
            overflow_next = 1'b1;
            state_next    = lwkd_pkg::ST_EMIT;
          end else begin
            hist_wr_en      = 1'b1;
            cnt_req.rd_en   = 1'b1;
            cnt_req.rd_addr = letter_index[lwkd_pkg::CNT_AW-1:0];
            state_next      = lwkd_pkg::ST_COUNT;
          end
        end
      end

      lwkd_pkg::ST_COUNT: begin
        // count of the new letter is back, bump it
        cnt_req.wr_en   = 1'b1;
        cnt_req.wr_addr = letter[lwkd_pkg::CNT_AW-1:0];
        cnt_req.wr_data = cnt_rd_data + lwkd_pkg::CNT_W'(1);
        if (cnt_rd_data == '0) begin
          distinct_next = distinct + lwkd_pkg::DIST_W'(1);
        end
        position_next = position + lwkd_pkg::POS_W'(1);
        state_next    = lwkd_pkg::ST_CHECK;
      end

      lwkd_pkg::ST_CHECK: begin
        if (distinct > target && start < position) begin
          hist_rd_en = 1'b1;
          state_next = lwkd_pkg::ST_HIST;
        end else begin
          state_next = lwkd_pkg::ST_SCORE;
        end
      end

      lwkd_pkg::ST_HIST: begin
        // front letter is back, fetch its count
        old_next        = hist_rd_data;
        cnt_req.rd_en   = 1'b1;
        cnt_req.rd_addr = hist_rd_data[lwkd_pkg::CNT_AW-1:0];
        state_next      = lwkd_pkg::ST_DEC;
      end

      lwkd_pkg::ST_DEC: begin
        if (cnt_rd_data != '0) begin
          cnt_req.wr_en   = 1'b1;
          cnt_req.wr_addr = old[lwkd_pkg::CNT_AW-1:0];
          cnt_req.wr_data = cnt_rd_data - lwkd_pkg::CNT_W'(1);
          if (cnt_rd_data == lwkd_pkg::CNT_W'(1) && distinct != '0) begin
            distinct_next = distinct - lwkd_pkg::DIST_W'(1);
          end
        end
        start_next = start + lwkd_pkg::POS_W'(1);
        state_next = lwkd_pkg::ST_CHECK;
      end

      lwkd_pkg::ST_SCORE: begin
        if (distinct == target &&
            $signed({1'b0, win_len}) > best) begin
          best_next = $signed({1'b0, win_len});
        end
        state_next = lwkd_pkg::ST_EMIT;
      end

      lwkd_pkg::ST_EMIT: begin
        if (!last) begin
          state_next = lwkd_pkg::ST_IDLE;
        end else if (!out_valid || out_ready) begin
          out_load     = 1'b1;
          string_clear = 1'b1;
          cnt_req.clear = 1'b1;
          state_next   = lwkd_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = lwkd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lwkd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // string state, cleared at reset and after each result
  always_ff @(posedge clk) begin
    if (rst || string_clear) begin
      distinct <= '0;
      position <= '0;
      start    <= '0;
      best     <= '1;
      overflow <= 1'b0;
    end else begin
      distinct <= distinct_next;
      position <= position_next;
      start    <= start_next;
      best     <= best_next;
      overflow <= overflow_next;
    end
  end

  // target register survives string clears
  always_ff @(posedge clk) begin
    if (rst) begin
      target <= lwkd_pkg::TARGET_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      target <= distinct_target;
    end
  end

  // letter payload held for the sequencer
  always_ff @(posedge clk) begin
    if (in_accept) begin
      letter <= letter_index;
      last   <= last_of_string;
    end
    old <= old_next;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      longest_length <= best;
      too_long       <= overflow;
    end
  end

endmodule

/* sv/lwkd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwkd_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lwkd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* sv/lwkd_count_store.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwkd_count_store
// per-letter counts in ram, with one valid bit per letter so a clear is instant
// ----------------------------------------------------------------------------
module lwkd_count_store (
  input  logic                       clk,
  input  logic                       rst,
  input  lwkd_pkg::cnt_req_t         req,
  output logic [lwkd_pkg::CNT_W-1:0] rd_data
);

  logic [lwkd_pkg::ALPHABET-1:0] valid;
  logic                          rd_valid;
  logic [lwkd_pkg::CNT_W-1:0]    ram_data;

  lwkd_ram #(
    .WIDTH (lwkd_pkg::CNT_W),
    .DEPTH (lwkd_pkg::ALPHABET)
  ) u_cnt_ram (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.wr_addr),
    .wr_data (req.wr_data),
    .rd_en   (req.rd_en),
    .rd_addr (req.rd_addr),
    .rd_data (ram_data)
  );

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_valid <= valid[req.rd_addr];
    end
  end

  // a letter never written since the last clear counts as zero
  assign rd_data = rd_valid ? ram_data : '0;

endmodule
